FILE: sv/rle_enc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the run-length byte encoder
// no dependencies; imported by every module of the encoder

package rle_enc_pkg;

   // encoding limits
   localparam int MAX_LITERALS = 254;
   localparam int MAX_RUN      = 65535;
   localparam int OUT_LANES    = 8;
   localparam int MIN_RUN      = 3;

   // marker byte that opens a run record
   localparam logic [7:0] RUN_MARK = 8'hFF;

   // derived widths
   localparam int LIT_CW = $clog2(MAX_LITERALS + 1);
   localparam int LIT_AW = (MAX_LITERALS > 1) ? $clog2(MAX_LITERALS) : 1;
   localparam int RUN_W  = 16;
   localparam int FILL_W = $clog2(OUT_LANES + 1);
   localparam int LANE_W = $clog2(OUT_LANES);

   // input item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_end;
   } req_type;

   // result item
   typedef struct packed {
      logic [7:0] out_byte0;
      logic [7:0] out_byte1;
      logic [7:0] out_byte2;
      logic [7:0] out_byte3;
      logic [7:0] out_byte4;
      logic [7:0] out_byte5;
      logic [7:0] out_byte6;
      logic [7:0] out_byte7;
      logic [3:0] valid_bytes;
      logic       last_of_item;
      logic       stream_done;
   } rsp_type;

   // sequencer to packer: one encoded byte, or a close of the current item
   typedef struct packed {
      logic       valid;
      logic       close;
      logic       done;
      logic [7:0] value;
   } pk_cmd_type;

   // write port of the literal memory
   typedef struct packed {
      logic              en;
      logic [LIT_AW-1:0] addr;
      logic [7:0]        data;
   } lit_wr_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_FLUSH_CNT,
      ST_FLUSH_DATA,
      ST_RUN_MARK,
      ST_RUN_HI,
      ST_RUN_LO,
      ST_RUN_VAL,
      ST_CLOSE
   } ctrl_state_type;

endpackage

FILE: sv/rle_byte_encoder.sv
`timescale 1ns / 1ps
// run-length byte encoder top level: sequencer, literal memory and output packer
// depends on rle_enc_pkg, rle_enc_ctrl, rle_enc_lits, rle_enc_pack
//
//   channel   ports                          direction   payload
//   req       req_valid req_stall req_data   in          req_type, one raw byte
//   rsp       rsp_valid rsp_stall rsp_data   out         rsp_type, up to 8 bytes
//
// an item that only extends a run, starts one, or buffers a single literal is
// taken in the idle state alone; other items go through action selection, which
// buffers literals, emits encoded bytes and closes the item.
// a literal chunk streams from the single read port of the literal memory.
// reset clears run state, counters and the result valid flag; literal memory
// contents and result data are not cleared. a stalled result backs up
// into the packer and holds the sequencer until it is taken.

module rle_byte_encoder
   import rle_enc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   pk_cmd_type        pk_cmd;
   logic              pk_ready;
   lit_wr_type        lit_wr;
   logic [LIT_AW-1:0] lit_raddr;
   logic [7:0]        lit_rdata;

   // run tracking and flush sequencing
   rle_enc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .pk_cmd    (pk_cmd),
      .pk_ready  (pk_ready),
      .lit_wr    (lit_wr),
      .lit_raddr (lit_raddr),
      .lit_rdata (lit_rdata)
   );

   // literal buffer
   rle_enc_lits u_lits (
      .clock     (clock),
      .lit_wr    (lit_wr),
      .lit_raddr (lit_raddr),
      .lit_rdata (lit_rdata)
   );

   // lane packing and result register
   rle_enc_pack u_pack (
      .clock     (clock),
      .reset     (reset),
      .pk_cmd    (pk_cmd),
      .pk_ready  (pk_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/rle_enc_lits.sv
`timescale 1ns / 1ps
// literal buffer memory: one write port, one read port with registered data
// depends on rle_enc_pkg

module rle_enc_lits
   import rle_enc_pkg::*;
(
   input  logic              clock,
   input  lit_wr_type        lit_wr,
   input  logic [LIT_AW-1:0] lit_raddr,
   output logic [7:0]        lit_rdata
);

   logic [7:0] lit_mem_ff [MAX_LITERALS];
   logic [7:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (lit_wr.en) begin
         lit_mem_ff[lit_wr.addr] <= lit_wr.data;
      end
   end

   // read port, registered data
   always_ff @(posedge clock) begin
      rdata_ff <= lit_mem_ff[lit_raddr];
   end

   assign lit_rdata = rdata_ff;

endmodule

FILE: sv/rle_enc_pack.sv
`timescale 1ns / 1ps
// output packer: gathers encoded bytes into lanes and holds the result register
// depends on rle_enc_pkg

module rle_enc_pack
   import rle_enc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  pk_cmd_type pk_cmd,
   output logic       pk_ready,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   logic [7:0]        lanes_ff [OUT_LANES];
   logic [7:0]        lanes_in [OUT_LANES];
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;
   logic              out_free;
   logic              full;
   logic              load;
   logic [7:0]        ob [8];

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign full     = (fill_ff == FILL_W'(OUT_LANES));
   assign pk_ready = pk_cmd.close ? out_free : (!full || out_free);

   // current lanes, unused ones forced to zero
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         ob[k] = 8'h00;
      end
      for (int k = 0; k < OUT_LANES; k++) begin
         if (FILL_W'(k) < fill_ff) begin
            ob[k] = lanes_ff[k];
         end
      end
   end

   // lane fill and result load
   always_comb begin
      lanes_in = lanes_ff;
      fill_in  = fill_ff;
      load     = 1'b0;
      rsp_data_in.out_byte0    = ob[0];
      rsp_data_in.out_byte1    = ob[1];
      rsp_data_in.out_byte2    = ob[2];
      rsp_data_in.out_byte3    = ob[3];
      rsp_data_in.out_byte4    = ob[4];
      rsp_data_in.out_byte5    = ob[5];
      rsp_data_in.out_byte6    = ob[6];
      rsp_data_in.out_byte7    = ob[7];
      rsp_data_in.valid_bytes  = 4'(fill_ff);
      rsp_data_in.last_of_item = 1'b0;
      rsp_data_in.stream_done  = 1'b0;
      if (pk_cmd.valid && pk_ready) begin
         if (pk_cmd.close) begin
            load                     = 1'b1;
            rsp_data_in.last_of_item = 1'b1;
            rsp_data_in.stream_done  = pk_cmd.done;
            fill_in                  = '0;
         end else if (full) begin
            load        = 1'b1;
            lanes_in[0] = pk_cmd.value;
            fill_in     = FILL_W'(1);
         end else begin
            lanes_in[fill_ff[LANE_W-1:0]] = pk_cmd.value;
            fill_in = fill_ff + 1'b1;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   // lane count never exceeds the lane number
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(OUT_LANES))
      else $error("packer fill above lane count");

   // a close always finds at least one pending byte
   a_close_nonempty: assert property (@(posedge clock) disable iff (reset)
      (pk_cmd.valid && pk_cmd.close) |-> (fill_ff != '0))
      else $error("close with empty lanes");

   // a presented result carries between one and all lanes
   a_rsp_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.valid_bytes != 4'd0 &&
                        rsp_data_ff.valid_bytes <= 4'(OUT_LANES)))
      else $error("result byte count out of range");
`endif

endmodule

FILE: sv/rle_enc_ctrl.sv
`timescale 1ns / 1ps
// encoder sequencer: run tracking, literal buffering and flush sequencing
// depends on rle_enc_pkg; drives rle_enc_lits and rle_enc_pack

module rle_enc_ctrl
   import rle_enc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output pk_cmd_type        pk_cmd,
   input  logic              pk_ready,
   output lit_wr_type        lit_wr,
   output logic [LIT_AW-1:0] lit_raddr,
   input  logic [7:0]        lit_rdata
);

   ctrl_state_type    state_ff, state_in;
   logic [7:0]        run_value_ff, run_value_in;
   logic [RUN_W-1:0]  run_len_ff, run_len_in;
   logic [LIT_CW-1:0] lit_cnt_ff, lit_cnt_in;
   logic [1:0]        lit_todo_ff, lit_todo_in;
   logic              pre_flush_ff, pre_flush_in;
   logic              run_emit_ff, run_emit_in;
   logic              end_close_ff, end_close_in;
   logic              end_flush_ff, end_flush_in;
   logic              end_item_ff, end_item_in;
   logic              emitted_ff, emitted_in;
   logic [7:0]        lit_val_ff, lit_val_in;
   logic [RUN_W-1:0]  emit_len_ff, emit_len_in;
   logic [7:0]        emit_val_ff, emit_val_in;
   logic [LIT_AW-1:0] idx_ff, idx_in;
   logic              match;
   logic [RUN_W-1:0]  next_len;
   logic              lit_full;
   logic              flush_last;

   assign match      = (run_len_ff != '0) && (req_data.data_byte == run_value_ff);
   assign next_len   = run_len_ff + 1'b1;
   assign lit_full   = (lit_cnt_ff == LIT_CW'(MAX_LITERALS));
   assign flush_last = ((LIT_CW'(idx_ff) + 1'b1) == lit_cnt_ff);
   assign req_stall  = (state_ff != ST_IDLE);

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state, register updates and port drives
   always_comb begin
      state_in     = state_ff;
      run_value_in = run_value_ff;
      run_len_in   = run_len_ff;
      lit_cnt_in   = lit_cnt_ff;
      lit_todo_in  = lit_todo_ff;
      pre_flush_in = pre_flush_ff;
      run_emit_in  = run_emit_ff;
      end_close_in = end_close_ff;
      end_flush_in = end_flush_ff;
      end_item_in  = end_item_ff;
      emitted_in   = emitted_ff;
      lit_val_in   = lit_val_ff;
      emit_len_in  = emit_len_ff;
      emit_val_in  = emit_val_ff;
      idx_in       = idx_ff;
      pk_cmd       = '0;
      lit_wr       = '0;
      lit_raddr    = idx_ff;
      case (state_ff)
         // take an item and apply the run update
         ST_IDLE: begin
            if (req_valid) begin
               emitted_in   = 1'b0;
               end_item_in  = req_data.stream_end;
               end_close_in = req_data.stream_end;
               end_flush_in = req_data.stream_end;
               pre_flush_in = 1'b0;
               run_emit_in  = 1'b0;
               lit_todo_in  = 2'd0;
               if (match) begin
                  run_len_in = next_len;
                  if (next_len == RUN_W'(MIN_RUN) && lit_cnt_ff != '0) begin
                     pre_flush_in = 1'b1;
                  end
                  if (next_len == RUN_W'(MAX_RUN)) begin
                     run_emit_in = 1'b1;
                     emit_len_in = next_len;
                     emit_val_in = run_value_ff;
                     run_len_in  = '0;
                  end
               end else begin
                  if (run_len_ff >= RUN_W'(MIN_RUN)) begin
                     run_emit_in = 1'b1;
                     emit_len_in = run_len_ff;
                     emit_val_in = run_value_ff;
                  end else if (run_len_ff == RUN_W'(2)) begin
                     lit_todo_in = 2'd2;
                     lit_val_in  = run_value_ff;
                  end else if (run_len_ff == RUN_W'(1)) begin
                     // single short run goes straight to the buffer
                     lit_wr.en   = 1'b1;
                     lit_wr.addr = lit_cnt_ff[LIT_AW-1:0];
                     lit_wr.data = run_value_ff;
                     lit_cnt_in  = lit_cnt_ff + 1'b1;
                  end
                  run_value_in = req_data.data_byte;
                  run_len_in   = RUN_W'(1);
               end
               if (req_data.stream_end || pre_flush_in || run_emit_in ||
                   lit_todo_in != 2'd0 || lit_cnt_in == LIT_CW'(MAX_LITERALS)) begin
                  state_in = ST_DISPATCH;
               end
            end
         end
         // pick the next pending action in stream order
         ST_DISPATCH: begin
            if (lit_full) begin
               state_in = ST_FLUSH_CNT;
            end else if (pre_flush_ff) begin
               pre_flush_in = 1'b0;
               if (lit_cnt_ff != '0) begin
                  state_in = ST_FLUSH_CNT;
               end
            end else if (run_emit_ff) begin
               state_in = ST_RUN_MARK;
            end else if (lit_todo_ff != 2'd0) begin
               lit_wr.en   = 1'b1;
               lit_wr.addr = lit_cnt_ff[LIT_AW-1:0];
               lit_wr.data = lit_val_ff;
               lit_cnt_in  = lit_cnt_ff + 1'b1;
               lit_todo_in = lit_todo_ff - 1'b1;
            end else if (end_close_ff) begin
               // stream end closes the open run
               end_close_in = 1'b0;
               if (run_len_ff >= RUN_W'(MIN_RUN)) begin
                  run_emit_in = 1'b1;
                  emit_len_in = run_len_ff;
                  emit_val_in = run_value_ff;
               end else begin
                  lit_todo_in = run_len_ff[1:0];
                  lit_val_in  = run_value_ff;
               end
               run_len_in   = '0;
               run_value_in = 8'h00;
            end else if (end_flush_ff) begin
               end_flush_in = 1'b0;
               if (lit_cnt_ff != '0) begin
                  state_in = ST_FLUSH_CNT;
               end
            end else if (emitted_ff) begin
               state_in = ST_CLOSE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         // literal chunk header, prefetch first entry
         ST_FLUSH_CNT: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.value = 8'(lit_cnt_ff);
            lit_raddr    = '0;
            if (pk_ready) begin
               idx_in     = '0;
               emitted_in = 1'b1;
               state_in   = ST_FLUSH_DATA;
            end
         end
         // literal bytes, read address runs one ahead of the pushed byte
         ST_FLUSH_DATA: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.value = lit_rdata;
            if (pk_ready) begin
               if (flush_last) begin
                  lit_cnt_in = '0;
                  state_in   = ST_DISPATCH;
               end else begin
                  idx_in    = idx_ff + 1'b1;
                  lit_raddr = idx_ff + 1'b1;
               end
            end
         end
         // run record: marker, length high, length low, value
         ST_RUN_MARK: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.value = RUN_MARK;
            if (pk_ready) begin
               state_in = ST_RUN_HI;
            end
         end
         ST_RUN_HI: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.value = emit_len_ff[15:8];
            if (pk_ready) begin
               state_in = ST_RUN_LO;
            end
         end
         ST_RUN_LO: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.value = emit_len_ff[7:0];
            if (pk_ready) begin
               state_in = ST_RUN_VAL;
            end
         end
         ST_RUN_VAL: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.value = emit_val_ff;
            if (pk_ready) begin
               run_emit_in = 1'b0;
               emitted_in  = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         // mark the final result of this item
         ST_CLOSE: begin
            pk_cmd.valid = 1'b1;
            pk_cmd.close = 1'b1;
            pk_cmd.done  = end_item_ff;
            if (pk_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // run state, counters and pending flags
   always_ff @(posedge clock) begin
      if (reset) begin
         run_value_ff <= 8'h00;
         run_len_ff   <= '0;
         lit_cnt_ff   <= '0;
         lit_todo_ff  <= 2'd0;
         pre_flush_ff <= 1'b0;
         run_emit_ff  <= 1'b0;
         end_close_ff <= 1'b0;
         end_flush_ff <= 1'b0;
         end_item_ff  <= 1'b0;
         emitted_ff   <= 1'b0;
      end else begin
         run_value_ff <= run_value_in;
         run_len_ff   <= run_len_in;
         lit_cnt_ff   <= lit_cnt_in;
         lit_todo_ff  <= lit_todo_in;
         pre_flush_ff <= pre_flush_in;
         run_emit_ff  <= run_emit_in;
         end_close_ff <= end_close_in;
         end_flush_ff <= end_flush_in;
         end_item_ff  <= end_item_in;
         emitted_ff   <= emitted_in;
      end
   end

   // captured run record, literal value and flush index
   always_ff @(posedge clock) begin
      lit_val_ff  <= lit_val_in;
      emit_len_ff <= emit_len_in;
      emit_val_ff <= emit_val_in;
      idx_ff      <= idx_in;
   end

`ifndef SYNTHESIS
   // a full literal buffer is always flushed before the next item
   a_idle_not_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (lit_cnt_ff != LIT_CW'(MAX_LITERALS)))
      else $error("literal buffer left full at idle");

   // the flush index stays inside the filled part of the buffer
   a_flush_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH_DATA) |-> (LIT_CW'(idx_ff) < lit_cnt_ff))
      else $error("flush read beyond literal count");

   // after a stream end item all run and literal state is back to empty
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) != ST_IDLE && state_ff == ST_IDLE && end_item_ff)
      |-> (run_len_ff == '0 && lit_cnt_ff == '0))
      else $error("state not cleared after stream end");

   // the open run never reaches the cap
   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (run_len_ff < RUN_W'(MAX_RUN)))
      else $error("open run at or above cap");
`endif

endmodule
